>>> hdl/ita_pkg.sv
// Shared types, constants and helper functions of the integer to ASCII converter.
`default_nettype none

package ita_pkg;

	// Field widths of the channels.
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned MINDIG_W = 5;
	localparam int unsigned CHAR_W   = 7;
	localparam int unsigned LEN_W    = 5;

	// Conversion constants.
	localparam logic [VALUE_W-1:0]  HEX_THRESHOLD = 32'd500000000;
	localparam logic [MINDIG_W-1:0] HEX_MIN_CAP   = 5'd15;
	localparam logic [MINDIG_W-1:0] DEC_MIN_CAP   = 5'd16;
	localparam int unsigned         BCD_DIGITS    = 10;
	localparam int unsigned         BCD_W         = 4 * BCD_DIGITS;
	localparam int unsigned         MAX_DIGITS    = 16;
	localparam int unsigned         DIG_W         = 4 * MAX_DIGITS;
	localparam int unsigned         BITS_PER_STEP = 2;
	localparam int unsigned         CONV_STEPS    = VALUE_W / BITS_PER_STEP;
	localparam int unsigned         STEP_CNT_W    = $clog2(CONV_STEPS);

	// ASCII codes.
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_UPPER = 7'h41;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

	// Controller states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SIZE = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic size;
		logic advance;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_hex;
		logic last;
	} status_t;

	// One shift-and-add-3 step: adjust every BCD digit, then shift one bit in.
	function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
	                                              input logic bit_in);
		logic [BCD_W-1:0] adj;
		adj = bcd;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (adj[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
			end
		end
		return {adj[BCD_W-2:0], bit_in};
	endfunction

	// Character of one digit, uppercase for hexadecimal digits.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = ASCII_ZERO + {3'b000, d};
		end else begin
			c = ASCII_UPPER + {3'b000, d - 4'd10};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> hdl/ita_if.sv
// Channel interfaces: the value word going in and the character word coming out.
`default_nettype none

interface ita_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] value_bits;
	logic        is_signed;
	logic [4:0]  min_digits;

	modport source (output valid, output value_bits, output is_signed, output min_digits,
	                input ready);
	modport sink   (input valid, input value_bits, input is_signed, input min_digits,
	                output ready);
endinterface

interface ita_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic       last_char;
	logic [4:0] total_length;

	modport source (output valid, output char_code, output last_char, output total_length,
	                input ready);
	modport sink   (input valid, input char_code, input last_char, input total_length,
	                output ready);
endinterface

`default_nettype wire

>>> hdl/ita_dp.sv
// Datapath: magnitude, BCD conversion, digit buffer and character selection.
`default_nettype none

module ita_dp (
	input  wire                    clk,
	input  wire                    arst_n,
	input  ita_pkg::cmd_t          cmd,
	output ita_pkg::status_t       status,
	input  wire [31:0]             value_bits,
	input  wire                    is_signed,
	input  wire [4:0]              min_digits,
	output logic [6:0]             char_code,
	output logic                   last_char,
	output logic [4:0]             total_length
);
	import ita_pkg::*;

	logic [VALUE_W-1:0]  mag_q;
	logic [VALUE_W-1:0]  shift_q;
	logic [BCD_W-1:0]    bcd_q;
	logic                neg_q;
	logic [MINDIG_W-1:0] md_q;
	logic [DIG_W-1:0]    dig_q;
	logic [3:0]          pos_q;
	logic [LEN_W-1:0]    len_q;
	logic                sign_pend_q;

	logic                neg_in;
	logic                is_hex;
	logic [DIG_W-1:0]    dig_src;
	logic [LEN_W-1:0]    ndig;
	logic [MINDIG_W-1:0] want;
	logic [LEN_W-1:0]    cnt;

	// Sign and magnitude of the incoming word.
	assign neg_in = is_signed & value_bits[VALUE_W-1];
	assign is_hex = (mag_q > HEX_THRESHOLD);

	// Digits of the chosen radix, least significant nibble first.
	assign dig_src = is_hex ? {{(DIG_W-VALUE_W){1'b0}}, mag_q}
	                        : {{(DIG_W-BCD_W){1'b0}}, bcd_q};

	// Significant digit count: position of the highest nonzero digit, at least one.
	always_comb begin
		ndig = LEN_W'(1);
		for (int i = 1; i < MAX_DIGITS; i++) begin
			if (dig_src[4*i +: 4] != 4'd0) begin
				ndig = LEN_W'(i + 1);
			end
		end
	end

	// Minimum width saturates differently for each radix; pad up to it.
	always_comb begin
		if (is_hex) begin
			want = (md_q > HEX_MIN_CAP) ? HEX_MIN_CAP : md_q;
		end else begin
			want = (md_q > DEC_MIN_CAP) ? DEC_MIN_CAP : md_q;
		end
		cnt = (ndig > want) ? ndig : want;
	end

	// Magnitude and conversion registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q   <= neg_in ? (~value_bits + 32'd1) : value_bits;
			shift_q <= neg_in ? (~value_bits + 32'd1) : value_bits;
			bcd_q   <= '0;
			neg_q   <= neg_in;
			md_q    <= min_digits;
		end else if (cmd.step) begin
			bcd_q   <= dabble(dabble(bcd_q, shift_q[VALUE_W-1]), shift_q[VALUE_W-2]);
			shift_q <= {shift_q[VALUE_W-3:0], 2'b00};
		end
	end

	// Digit buffer and line length, captured once the digits are known.
	always_ff @(posedge clk) begin
		if (cmd.size) begin
			dig_q <= dig_src;
			len_q <= cnt + LEN_W'(neg_q);
		end
	end

	// Emission position: the sign first, then digits from the most significant down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sign_pend_q <= 1'b0;
			pos_q       <= '0;
		end else if (cmd.size) begin
			sign_pend_q <= neg_q;
			pos_q       <= 4'(cnt - LEN_W'(1));
		end else if (cmd.advance) begin
			if (sign_pend_q) begin
				sign_pend_q <= 1'b0;
			end else begin
				pos_q <= pos_q - 4'd1;
			end
		end
	end

	// Output word.
	assign char_code    = sign_pend_q ? ASCII_MINUS : digit_char(dig_q[4*pos_q +: 4]);
	assign last_char    = !sign_pend_q && (pos_q == 4'd0);
	assign total_length = len_q;

	assign status.is_hex = is_hex;
	assign status.last   = last_char;

endmodule

`default_nettype wire

>>> hdl/ita_ctrl.sv
// Controller: state machine sequencing load, conversion, sizing and emission.
`default_nettype none

module ita_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire               out_ready,
	input  ita_pkg::status_t  status,
	output ita_pkg::cmd_t     cmd
);
	import ita_pkg::*;

	state_t                state_q;
	state_t                state_nxt;
	logic [STEP_CNT_W-1:0] step_cnt_q;
	logic                  conv_done;

	assign conv_done = (step_cnt_q == STEP_CNT_W'(CONV_STEPS - 1));

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);

	// Commands to the datapath.
	always_comb begin
		cmd.load    = in_ready && in_valid;
		cmd.step    = (state_q == ST_CONV) && !status.is_hex;
		cmd.size    = (state_q == ST_SIZE);
		cmd.advance = out_valid && out_ready;
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_CONV;
				end
			end
			ST_CONV: begin
				if (status.is_hex || conv_done) begin
					state_nxt = ST_SIZE;
				end
			end
			ST_SIZE: begin
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready && status.last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State and conversion step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				step_cnt_q <= '0;
			end else if (cmd.step) begin
				step_cnt_q <= step_cnt_q + STEP_CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/int_to_ascii_decimal_hex.sv
// Top level of the integer to ASCII converter.
//
// A value word on value_ch carries a 32-bit value, a signed flag and a minimum
// digit count. The block writes the value as ASCII text and sends it on char_ch,
// one character per word, with last_char on the final character and the line
// length in total_length on every word. Negative signed values get a leading
// minus sign. Magnitudes above 500000000 are written in uppercase hexadecimal,
// all others in decimal, both zero-padded on the left.
//
// One value is handled at a time; value_ch.ready is high only while idle.
// Decimal conversion runs a shift-and-add-3 unit two bits per cycle over the
// 32-bit magnitude before the first character appears; hexadecimal skips that
// unit. Characters then leave one per cycle while char_ch is ready, from 1 to
// 17 characters per value.
// A stall on char_ch holds the current character; nothing is lost.
// Reset returns the controller to idle and drops any value in progress.
`default_nettype none

module int_to_ascii_decimal_hex (
	input  wire        clk,
	input  wire        arst_n,
	ita_in_if.sink     value_ch,
	ita_out_if.source  char_ch
);
	import ita_pkg::*;

	cmd_t    cmd;
	status_t status;

	ita_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (value_ch.valid),
		.in_ready  (value_ch.ready),
		.out_valid (char_ch.valid),
		.out_ready (char_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	ita_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.value_bits   (value_ch.value_bits),
		.is_signed    (value_ch.is_signed),
		.min_digits   (value_ch.min_digits),
		.char_code    (char_ch.char_code),
		.last_char    (char_ch.last_char),
		.total_length (char_ch.total_length)
	);

endmodule

`default_nettype wire

>>> hdl/ita_checker.sv
// Port-level checks of the integer to ASCII converter and their bind.
`default_nettype none

module ita_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_ready,
	input wire       out_valid,
	input wire       out_ready,
	input wire [6:0] char_code,
	input wire       last_char,
	input wire [4:0] total_length
);

	// A stalled character word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last_char))
		else $error("stalled character word changed");

	// No new value is taken while characters are still going out.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("value accepted while emitting");

	// A line continues after a non-final character with the same length.
	a_line_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_char |=>
			out_valid && (total_length == $past(total_length)))
		else $error("line broken or length changed within a line");

	// The line length stays within one sign and sixteen digits.
	a_length_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (total_length >= 5'd1) && (total_length <= 5'd17))
		else $error("line length out of range");

	// No character is offered in the cycle after a value is accepted.
	a_no_early_char: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("character before conversion");

endmodule

bind int_to_ascii_decimal_hex ita_checker u_ita_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (value_ch.valid),
	.in_ready     (value_ch.ready),
	.out_valid    (char_ch.valid),
	.out_ready    (char_ch.ready),
	.char_code    (char_ch.char_code),
	.last_char    (char_ch.last_char),
	.total_length (char_ch.total_length)
);

`default_nettype wire
